// ----- sv/sopmq_pkg.sv -----
// ----------------------------------------------------------------------------
// sopmq_pkg
// Shared types and codes for the sorted position min-queue.
// ----------------------------------------------------------------------------
package sopmq_pkg;

    localparam int KEY_W = 40;

    localparam logic [1:0] KIND_ADD  = 2'd0;
    localparam logic [1:0] KIND_PEEK = 2'd1;
    localparam logic [1:0] KIND_POP  = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] pair_index;
        logic [23:0] data_offset;
    } t_cmd;

    typedef struct packed {
        logic       ok;
        logic [4:0] count;
    } t_result;

endpackage

// ----- sv/sorted_position_min_queue_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_position_min_queue_unit
// Bounded priority queue of (pair_index, data_offset) words, kept sorted.
// Pop, refused add or add to an empty queue: strobe in the cycle after start.
// Peek: RAM read, then compare. Add: one compare-and-shift step per cycle, one RAM.
// A new word may be started in the cycle its predecessor's result is strobed.
// Synchronous active-low reset empties the queue; entry storage is not cleared.
// ----------------------------------------------------------------------------
module sorted_position_min_queue_unit #(
    parameter int QUEUE_SLOTS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  sopmq_pkg::t_cmd       i_cmd,
    output logic                  o_valid,
    output sopmq_pkg::t_result    o_result
);

    localparam int AW = (QUEUE_SLOTS > 2) ? $clog2(QUEUE_SLOTS) : 1;
    localparam logic [AW-1:0] HeldMax = AW'(QUEUE_SLOTS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_PLACE,
        ST_PEEK
    } t_state;

    logic [sopmq_pkg::KEY_W-1:0] mem [QUEUE_SLOTS];

    t_state                      r_state, n_state;
    logic [AW-1:0]               r_held,  n_held;
    logic [AW-1:0]               r_pos,   n_pos;
    logic [1:0]                  r_kind,  n_kind;
    logic [sopmq_pkg::KEY_W-1:0] r_key,   n_key;
    logic                        r_valid, n_valid;
    logic                        r_ok,    n_ok;
    logic [sopmq_pkg::KEY_W-1:0] r_rd_data;

    logic                        mem_we;
    logic [AW-1:0]               mem_wa;
    logic [sopmq_pkg::KEY_W-1:0] mem_wd;
    logic                        mem_re;
    logic [AW-1:0]               mem_ra;

    logic [sopmq_pkg::KEY_W-1:0] in_key;

    assign in_key = {i_cmd.pair_index, i_cmd.data_offset};

    always_comb begin
        n_state = r_state;
        n_held  = r_held;
        n_pos   = r_pos;
        n_kind  = r_kind;
        n_key   = r_key;
        n_valid = 1'b0;
        n_ok    = r_ok;
        mem_we  = 1'b0;
        mem_wa  = r_pos;
        mem_wd  = r_key;
        mem_re  = 1'b0;
        mem_ra  = r_pos - AW'(1);
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_kind = i_cmd.kind;
                    n_key  = in_key;
                    n_ok   = 1'b0;
                    case (i_cmd.kind)
                        sopmq_pkg::KIND_ADD: begin
                            if (r_held == HeldMax) begin
                                n_valid = 1'b1;
                            end else if (r_held == '0) begin
                                mem_we  = 1'b1;
                                mem_wa  = '0;
                                mem_wd  = in_key;
                                n_held  = r_held + AW'(1);
                                n_ok    = 1'b1;
                                n_valid = 1'b1;
                            end else begin
                                n_pos   = r_held;
                                mem_re  = 1'b1;
                                mem_ra  = r_held - AW'(1);
                                n_state = ST_SHIFT;
                            end
                        end
                        sopmq_pkg::KIND_PEEK: begin
                            if (r_held == '0) begin
                                n_valid = 1'b1;
                            end else begin
                                mem_re  = 1'b1;
                                mem_ra  = r_held - AW'(1);
                                n_state = ST_PEEK;
                            end
                        end
                        sopmq_pkg::KIND_POP: begin
                            if (r_held != '0) begin
                                n_held = r_held - AW'(1);
                                n_ok   = 1'b1;
                            end
                            n_valid = 1'b1;
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_SHIFT: begin
                mem_we = 1'b1;
                mem_wa = r_pos;
                if (r_key > r_rd_data) begin
                    // entry below is smaller: move it up one slot
                    mem_wd = r_rd_data;
                    n_pos  = r_pos - AW'(1);
                    if (r_pos == AW'(1)) begin
                        n_state = ST_PLACE;
                    end else begin
                        mem_re = 1'b1;
                        mem_ra = r_pos - AW'(2);
                    end
                end else begin
                    mem_wd  = r_key;
                    n_held  = r_held + AW'(1);
                    n_ok    = 1'b1;
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_PLACE: begin
                mem_we  = 1'b1;
                mem_wa  = r_pos;
                mem_wd  = r_key;
                n_held  = r_held + AW'(1);
                n_ok    = 1'b1;
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end
            ST_PEEK: begin
                n_ok    = (r_rd_data == r_key);
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_held  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            r_valid <= n_valid;
        end
        r_pos  <= n_pos;
        r_kind <= n_kind;
        r_key  <= n_key;
        r_ok   <= n_ok;
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_valid        = r_valid;
    assign o_result.ok    = r_ok;
    assign o_result.count = 5'(r_held);

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= HeldMax)
        else $error("queue holds more words than allowed");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy && r_kind == sopmq_pkg::KIND_ADD |-> r_pos <= r_held)
        else $error("insert position beyond queue fill");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_kind == sopmq_pkg::KIND_POP && r_ok |->
            r_held == $past(r_held) - AW'(1))
        else $error("pop did not lower fill by one");

    a_add_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_kind == sopmq_pkg::KIND_ADD && r_ok |->
            r_held == $past(r_held) + AW'(1))
        else $error("add did not raise fill by one");

endmodule
